// ===== rtl/core/indexed_linked_list_engine_macros.svh =====
// Assertion macros shared by the checker of the indexed linked list engine.
`ifndef INDEXED_LINKED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LINKED_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ILLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/core/ille_pkg.sv =====
// Package with types and constants of the indexed linked list engine.
`default_nettype none

package ille_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int FUNC_W    = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_HEAD_INS = 3'd0,
        FN_TAIL_INS = 3'd1,
        FN_SORT_INS = 3'd2,
        FN_HEAD_RM  = 3'd3,
        FN_TAIL_RM  = 3'd4,
        FN_MATCH_RM = 3'd5,
        FN_SEARCH   = 3'd6
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [VAL_W-1:0] operand_value;
    } t_in;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] removed_value;
    } t_out;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_RD_FREE,
        DP_HEAD_PUSH,
        DP_POP_FREE,
        DP_RD_CUR,
        DP_STEP,
        DP_INS_SLOT,
        DP_INS_LINK,
        DP_HEAD_POP,
        DP_TAIL_HIT,
        DP_MATCH_HIT,
        DP_REL_SLOT,
        DP_REL_LINK
    } t_dp_op;

    typedef struct packed {
        logic                    clr_last;
        logic                    free_null;
        logic                    cur_null;
        logic                    prev_null;
        logic                    link_null;
        logic                    val_less;
        logic                    val_equal;
        logic signed [VAL_W-1:0] removed;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/ille_dp.sv =====
// Datapath of the indexed linked list engine: slot memories and list pointers.
`default_nettype none

module ille_dp #(
    parameter int SLOTS = ille_pkg::SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  ille_pkg::t_dp_op                       i_cmd,
    input  wire logic signed [ille_pkg::VAL_W-1:0] i_value,
    output ille_pkg::t_dp_status                   o_status
);
    import ille_pkg::*;

    localparam int PW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PW-1:0] NULL_P = PW'(SLOTS);

    logic [PW-1:0]          links [SLOTS];
    logic signed [VAL_W-1:0] values [SLOTS];

    logic [PW-1:0]           r_list_head;
    logic [PW-1:0]           r_free_head;
    logic [IW-1:0]           r_clr;
    logic [PW-1:0]           r_prev;
    logic [PW-1:0]           r_cur;
    logic [PW-1:0]           r_m;
    logic [PW-1:0]           r_nxt;
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_removed;
    logic [PW-1:0]           r_link_q;
    logic signed [VAL_W-1:0] r_value_q;

    logic                    rd_en;
    logic [PW-1:0]           rd_ptr;
    logic                    lk_we;
    logic [PW-1:0]           lk_wptr;
    logic [PW-1:0]           lk_wdata;
    logic                    vl_we;

    logic                    cur_null;
    logic                    prev_null;
    logic                    link_null;

    assign cur_null  = (r_cur >= NULL_P);
    assign prev_null = (r_prev >= NULL_P);
    assign link_null = (r_link_q >= NULL_P);

    always_comb begin
        rd_en    = 1'b0;
        rd_ptr   = r_cur;
        lk_we    = 1'b0;
        lk_wptr  = r_cur;
        lk_wdata = r_free_head;
        vl_we    = 1'b0;
        unique case (i_cmd)
            DP_CLEAR: begin
                lk_we    = 1'b1;
                lk_wptr  = PW'(r_clr);
                lk_wdata = PW'(r_clr) + PW'(1);
            end
            DP_RD_FREE: begin
                rd_en  = 1'b1;
                rd_ptr = r_free_head;
            end
            DP_HEAD_PUSH: begin
                lk_we    = 1'b1;
                lk_wptr  = r_m;
                lk_wdata = r_list_head;
                vl_we    = 1'b1;
            end
            DP_POP_FREE, DP_RD_CUR: begin
                rd_en = !cur_null;
            end
            DP_STEP: begin
                rd_en  = !link_null;
                rd_ptr = r_link_q;
            end
            DP_INS_SLOT: begin
                lk_we    = 1'b1;
                lk_wptr  = r_m;
                lk_wdata = r_cur;
                vl_we    = 1'b1;
            end
            DP_INS_LINK: begin
                lk_we    = 1'b1;
                lk_wptr  = r_prev;
                lk_wdata = r_m;
            end
            DP_HEAD_POP, DP_REL_SLOT: begin
                lk_we = 1'b1;
            end
            DP_REL_LINK: begin
                lk_we    = 1'b1;
                lk_wptr  = r_prev;
                lk_wdata = r_nxt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_link_q  <= links[rd_ptr[IW-1:0]];
            r_value_q <= values[rd_ptr[IW-1:0]];
        end
        if (lk_we) begin
            links[lk_wptr[IW-1:0]] <= lk_wdata;
        end
        if (vl_we) begin
            values[r_m[IW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= NULL_P;
            r_free_head <= '0;
            r_clr       <= '0;
        end else begin
            unique case (i_cmd)
                DP_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                end
                DP_HEAD_PUSH: begin
                    r_free_head <= r_link_q;
                    r_list_head <= r_m;
                end
                DP_POP_FREE: begin
                    r_free_head <= r_link_q;
                end
                DP_INS_SLOT: begin
                    if (prev_null) begin
                        r_list_head <= r_m;
                    end
                end
                DP_HEAD_POP: begin
                    r_list_head <= r_link_q;
                    r_free_head <= r_cur;
                end
                DP_REL_SLOT: begin
                    r_free_head <= r_cur;
                    if (prev_null) begin
                        r_list_head <= r_nxt;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LOAD: begin
                r_val     <= i_value;
                r_prev    <= NULL_P;
                r_cur     <= r_list_head;
                r_removed <= '0;
            end
            DP_RD_FREE: begin
                r_m <= r_free_head;
            end
            DP_STEP: begin
                r_prev <= r_cur;
                r_cur  <= r_link_q;
            end
            DP_HEAD_POP: begin
                r_removed <= r_value_q;
            end
            DP_TAIL_HIT: begin
                r_removed <= r_value_q;
                r_nxt     <= r_link_q;
            end
            DP_MATCH_HIT: begin
                r_nxt <= r_link_q;
            end
            default: begin
            end
        endcase
    end

    assign o_status.clr_last  = (r_clr == IW'(SLOTS - 1));
    assign o_status.free_null = (r_free_head >= NULL_P);
    assign o_status.cur_null  = cur_null;
    assign o_status.prev_null = prev_null;
    assign o_status.link_null = link_null;
    assign o_status.val_less  = (r_value_q < r_val);
    assign o_status.val_equal = (r_value_q == r_val);
    assign o_status.removed   = r_removed;

endmodule

`default_nettype wire

// ===== rtl/core/ille_ctrl.sv =====
// Controller of the indexed linked list engine: operation sequencer and result register.
`default_nettype none

module ille_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  ille_pkg::t_in        i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output ille_pkg::t_out       o_out,
    output ille_pkg::t_dp_op     o_cmd,
    input  ille_pkg::t_dp_status i_status
);
    import ille_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_POP,
        ST_HEAD_PUSH,
        ST_HEAD_POP,
        ST_WALK,
        ST_INS_SLOT,
        ST_INS_LINK,
        ST_REL_SLOT,
        ST_REL_LINK,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_func  r_func;
    logic   r_ok;
    logic   n_ok;
    logic   r_out_valid;
    t_out   r_out;
    logic   out_free;
    logic   is_insert;
    logic   walk_cont;

    assign out_free  = !r_out_valid || i_out_ready;
    assign is_insert = (r_func == FN_TAIL_INS) || (r_func == FN_SORT_INS);
    assign walk_cont = (r_func == FN_TAIL_INS) || i_status.val_less;

    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        o_cmd   = DP_NOP;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd = DP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_ok    = 1'b0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                unique case (r_func)
                    FN_HEAD_INS, FN_TAIL_INS, FN_SORT_INS: begin
                        if (i_status.free_null) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd   = DP_RD_FREE;
                            n_state = (r_func == FN_HEAD_INS) ? ST_HEAD_PUSH : ST_POP;
                        end
                    end
                    FN_HEAD_RM: begin
                        if (i_status.cur_null) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd   = DP_RD_CUR;
                            n_state = ST_HEAD_POP;
                        end
                    end
                    FN_TAIL_RM, FN_MATCH_RM, FN_SEARCH: begin
                        if (i_status.cur_null) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd   = DP_RD_CUR;
                            n_state = ST_WALK;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_POP: begin
                o_cmd   = DP_POP_FREE;
                n_state = i_status.cur_null ? ST_INS_SLOT : ST_WALK;
            end
            ST_HEAD_PUSH: begin
                o_cmd   = DP_HEAD_PUSH;
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_HEAD_POP: begin
                o_cmd   = DP_HEAD_POP;
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_WALK: begin
                if (is_insert) begin
                    if (!walk_cont) begin
                        n_state = ST_INS_SLOT;
                    end else begin
                        o_cmd = DP_STEP;
                        if (i_status.link_null) begin
                            n_state = ST_INS_SLOT;
                        end
                    end
                end else if (r_func == FN_TAIL_RM) begin
                    if (i_status.link_null) begin
                        o_cmd   = DP_TAIL_HIT;
                        n_state = ST_REL_SLOT;
                    end else begin
                        o_cmd = DP_STEP;
                    end
                end else if (i_status.val_equal) begin
                    if (r_func == FN_MATCH_RM) begin
                        o_cmd   = DP_MATCH_HIT;
                        n_state = ST_REL_SLOT;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = ST_DONE;
                    end
                end else if (i_status.link_null) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd = DP_STEP;
                end
            end
            ST_INS_SLOT: begin
                o_cmd = DP_INS_SLOT;
                if (i_status.prev_null) begin
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_INS_LINK;
                end
            end
            ST_INS_LINK: begin
                o_cmd   = DP_INS_LINK;
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_REL_SLOT: begin
                o_cmd = DP_REL_SLOT;
                if (i_status.prev_null) begin
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_REL_LINK;
                end
            end
            ST_REL_LINK: begin
                o_cmd   = DP_REL_LINK;
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
            r_func      <= FN_HEAD_INS;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
            if (r_state == ST_IDLE && i_in_valid) begin
                r_func <= t_func'(i_in.func);
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.ok            <= r_ok;
            r_out.removed_value <= i_status.removed;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_linked_list_engine.sv =====
// Top level of the indexed linked list engine.
// The list lives in SLOTS value/link slots with a free list chained through the same links;
// after reset the engine builds the free chain before it accepts a transaction. Head
// insert and head remove work at the head of the list. Tail insert, sorted insert, tail remove,
// remove match and search walk the list one link per cycle through the single read port of
// the slot memory. One transaction is in flight at a time; the next one is accepted while
// the previous result waits.
`default_nettype none

module indexed_linked_list_engine #(
    parameter int SLOTS = ille_pkg::SLOTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  ille_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output ille_pkg::t_out o_out
);
    import ille_pkg::*;

    t_dp_op     cmd;
    t_dp_status status;

    ille_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    ille_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_in.operand_value),
        .o_status (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ille_checker.sv =====
// Port-level checker of the indexed linked list engine and its bind.
`default_nettype none
`include "indexed_linked_list_engine_macros.svh"

module ille_checker (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input ille_pkg::t_in  i_in,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input ille_pkg::t_out o_out
);
    import ille_pkg::*;

    logic in_acc;
    logic out_wait;
    logic out_fail;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_wait = o_out_valid && !i_out_ready;
    assign out_fail = o_out_valid && !o_out.ok;

    `ILLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out))
    `ILLE_ASSERT_SAME(a_fail_no_value, i_clk, i_rst_n, out_fail, o_out.removed_value == 0)
    `ILLE_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_acc, !o_in_ready)
    `ILLE_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_acc, !$rose(o_out_valid))

endmodule

bind indexed_linked_list_engine ille_checker u_ille_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

// ===== verif/tb_indexed_linked_list_engine.sv =====
// Self-checking testbench for the indexed linked list engine with a list-level predictor.
module tb_indexed_linked_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ille_pkg::*;

    typedef logic signed [VAL_W-1:0] t_value;

    localparam int              NUM_SLOTS   = SLOTS_DEF;
    localparam logic [FUNC_W-1:0] FN_RESERVED = 3'd7;
    localparam t_value          VAL_MIN     = 32'sh8000_0000;
    localparam t_value          VAL_MAX     = 32'sh7FFF_FFFF;
    localparam int              SETTLE      = NUM_SLOTS + 10;
    localparam int              CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    t_value list_contents[$];
    t_out   predicted_replies[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     error_count = 0;
    int     cycle_count = 0;

    indexed_linked_list_engine #(
        .SLOTS(NUM_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_replies.size() == 0) begin
                $error("unexpected transaction: ok %0b removed_value %0d",
                       o_out.ok, o_out.removed_value);
                error_count++;
            end else begin
                want = predicted_replies.pop_front();
                if (o_out.ok !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, o_out.ok);
                    error_count++;
                end
                if (o_out.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed_value, o_out.removed_value);
                    error_count++;
                end
            end
        end
    end

    function automatic t_out predict_list_op(input t_in request);
        t_out   reply;
        t_value val;
        int     spot;
        int     depth;
        reply = '0;
        val   = request.operand_value;
        depth = list_contents.size();
        case (request.func)
            FN_HEAD_INS: begin
                if (depth < NUM_SLOTS) begin
                    list_contents.push_front(val);
                    reply.ok = 1'b1;
                end
            end
            FN_TAIL_INS: begin
                if (depth < NUM_SLOTS) begin
                    list_contents.push_back(val);
                    reply.ok = 1'b1;
                end
            end
            FN_SORT_INS: begin
                if (depth < NUM_SLOTS) begin
                    spot = 0;
                    while (spot < depth && list_contents[spot] < val) spot++;
                    list_contents.insert(spot, val);
                    reply.ok = 1'b1;
                end
            end
            FN_HEAD_RM: begin
                if (depth > 0) begin
                    reply.removed_value = list_contents.pop_front();
                    reply.ok = 1'b1;
                end
            end
            FN_TAIL_RM: begin
                if (depth > 0) begin
                    reply.removed_value = list_contents.pop_back();
                    reply.ok = 1'b1;
                end
            end
            FN_MATCH_RM, FN_SEARCH: begin
                spot = 0;
                while (spot < depth && list_contents[spot] != val) spot++;
                if (spot < depth) begin
                    reply.ok = 1'b1;
                    if (request.func == FN_MATCH_RM) list_contents.delete(spot);
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    function automatic t_in make_request(input logic [FUNC_W-1:0] op, input t_value val);
        t_in request;
        request.func = op;
        request.operand_value = val;
        return request;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(input int fill_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return FN_RESERVED;
        if (roll < fill_pct) begin
            case ($urandom_range(0, 2))
                0: return FN_HEAD_INS;
                1: return FN_TAIL_INS;
                default: return FN_SORT_INS;
            endcase
        end
        case ($urandom_range(0, 3))
            0: return FN_HEAD_RM;
            1: return FN_TAIL_RM;
            2: return FN_MATCH_RM;
            default: return FN_SEARCH;
        endcase
    endfunction

    function automatic t_value pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && list_contents.size() > 0)
            return list_contents[$urandom_range(0, list_contents.size() - 1)];
        if (roll < 75) return t_value'($urandom_range(0, 31)) - 16;
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return t_value'($urandom);
    endfunction

    task automatic send_request(input t_in request);
        t_out reply;
        i_in       <= request;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        reply = predict_list_op(request);
        predicted_replies.push_back(reply);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        while (predicted_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(make_request(FN_HEAD_RM, '0));
        send_request(make_request(FN_TAIL_RM, '0));
        send_request(make_request(FN_MATCH_RM, '0));
        send_request(make_request(FN_SEARCH, '0));
        send_request(make_request(FN_RESERVED, VAL_MAX));
        wait_replies_drained();
    endtask

    task automatic test_field_extremes();
        send_request(make_request(FN_HEAD_INS, VAL_MAX));
        send_request(make_request(FN_HEAD_INS, VAL_MIN));
        send_request(make_request(FN_SORT_INS, '0));
        send_request(make_request(FN_SORT_INS, '1));
        send_request(make_request(FN_TAIL_INS, 32'sh5555_5555));
        send_request(make_request(FN_SEARCH, VAL_MIN));
        send_request(make_request(FN_MATCH_RM, 32'sh5555_5555));
        send_request(make_request(FN_TAIL_RM, 32'shAAAA_AAAA));
        send_request(make_request(FN_HEAD_RM, VAL_MAX));
        wait_replies_drained();
    endtask

    task automatic test_unsorted_insert();
        send_request(make_request(FN_TAIL_INS, 32'sd5));
        send_request(make_request(FN_HEAD_INS, 32'sd7));
        send_request(make_request(FN_SORT_INS, 32'sd3));
        send_request(make_request(FN_SORT_INS, 32'sd100));
        send_request(make_request(FN_SEARCH, 32'sd6));
        send_request(make_request(FN_RESERVED, '1));
        wait_replies_drained();
    endtask

    // Traffic alternates between filling the list past full and draining it past empty.
    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        int                fill_pct;
        logic [FUNC_W-1:0] op;
        t_value            val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            fill_pct = ((n / 48) % 2 == 0) ? 75 : 30;
            op  = pick_func(fill_pct);
            val = pick_value();
            send_request(make_request(op, val));
        end
        wait_replies_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_field_extremes();
        test_unsorted_insert();
        test_random_traffic(190, 0, 0);
        test_random_traffic(190, 78, 0);
        test_random_traffic(190, 0, 78);
        test_random_traffic(190, 38, 38);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
